[rtl/core/cc20_pkg.sv]
`default_nettype none
package cc20_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] state_t;

    // Four words that one quarter round works on
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Control of the round unit: which round shape and which half of the quarter round
    typedef struct packed {
        logic diag;
        logic second;
    } round_ctl_t;

    localparam int BLOCK_WORDS = 8;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int ADDR_W = 6;
    localparam int CFG_W = 64;
    localparam int DATA_W = 64;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_KEY_LOW      = 3'd0;
    localparam logic [2:0] REG_KEY_MID_LOW  = 3'd1;
    localparam logic [2:0] REG_KEY_MID_HIGH = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH     = 3'd3;
    localparam logic [2:0] REG_START_CNT    = 3'd4;
    localparam logic [2:0] REG_NONCE        = 3'd5;

    // One half of a quarter round: rotations 16/12 in the first half, 8/7 in the second
    function automatic quad_t half_qr(quad_t q, logic second);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        quad_t r;
        a = q.a + q.b;
        d = q.d ^ a;
        d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
        c = q.c + d;
        b = q.b ^ c;
        b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/chacha20_stream_cipher.sv]
`default_nettype none
// ChaCha20 stream cipher (original form, 64-bit block counter and 64-bit nonce). Each
// 64-bit word on the input stream comes out XORed with its keystream word, so the same
// block encrypts and decrypts; eight words make one 64-byte block and tlast marks the
// eighth. Key, start counter and nonce are 64-bit registers at byte addresses 0x00 to
// 0x28; writing the start counter also reloads the running counter. Words 1 to 7 of a
// block are taken one per cycle while the output is not stalled. After word 0 the input
// is not ready while a single round unit applies one half quarter round to four columns
// or diagonals per cycle, followed by a feed-forward step and an output step.
// Configuration must be written while the stream is idle; the block itself does not
// enforce this.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // Input stream, tdata: data_in[63:0]
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [cc20_pkg::DATA_W-1:0]   s_tdata,
    // Output stream, tdata: data_out[63:0]; tlast: block_end
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [cc20_pkg::DATA_W-1:0]  m_tdata,
    output logic                         m_tlast,
    // Configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [cc20_pkg::ADDR_W-1:0]   paddr,
    input  wire [cc20_pkg::CFG_W-1:0]    pwdata,
    output logic [cc20_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);

    localparam int ROUND_STEPS = 4 * DOUBLE_ROUNDS;
    localparam int CNT_W = $clog2(ROUND_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROUND_STEPS - 1);
    localparam logic [2:0] LAST_POS = 3'(cc20_pkg::BLOCK_WORDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FEED,
        ST_EMIT
    } fsm_t;

    fsm_t                 state_reg;
    logic [CNT_W-1:0]     step_reg;
    logic [2:0]           pos_reg;
    cc20_pkg::state_t     work_reg;
    logic [63:0]          data_reg;
    logic [63:0]          blk_cnt_reg;
    logic [63:0]          key0_reg;
    logic [63:0]          key1_reg;
    logic [63:0]          key2_reg;
    logic [63:0]          key3_reg;
    logic [63:0]          start_reg;
    logic [63:0]          nonce_reg;
    logic                 m_valid_reg;
    logic [63:0]          m_data_reg;
    logic                 m_last_reg;

    cc20_pkg::state_t     init_state;
    cc20_pkg::state_t     round_out;
    cc20_pkg::round_ctl_t round_ctl;
    logic [63:0]          ks_word;
    logic                 out_free;
    logic                 out_load;
    logic                 in_xfer;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[cc20_pkg::ADDR_W-1:3];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // A new word enters the output register this cycle
    assign out_load = ((state_reg == ST_IDLE) && in_xfer && (pos_reg != 3'd0))
                   || ((state_reg == ST_EMIT) && out_free);

    // Build the block input state from constants, key, counter and nonce
    always_comb
    begin
        init_state[0]  = cc20_pkg::SIGMA0;
        init_state[1]  = cc20_pkg::SIGMA1;
        init_state[2]  = cc20_pkg::SIGMA2;
        init_state[3]  = cc20_pkg::SIGMA3;
        init_state[4]  = key0_reg[31:0];
        init_state[5]  = key0_reg[63:32];
        init_state[6]  = key1_reg[31:0];
        init_state[7]  = key1_reg[63:32];
        init_state[8]  = key2_reg[31:0];
        init_state[9]  = key2_reg[63:32];
        init_state[10] = key3_reg[31:0];
        init_state[11] = key3_reg[63:32];
        init_state[12] = blk_cnt_reg[31:0];
        init_state[13] = blk_cnt_reg[63:32];
        init_state[14] = nonce_reg[31:0];
        init_state[15] = nonce_reg[63:32];
    end

    // Step order: column first half, column second half, diagonal first, diagonal second
    assign round_ctl = '{diag: step_reg[1], second: step_reg[0]};

    cc20_round u_round (
        .state_in  (work_reg),
        .ctl       (round_ctl),
        .state_out (round_out)
    );

    // Select the keystream word at the current position
    assign ks_word = {work_reg[{pos_reg, 1'b1}], work_reg[{pos_reg, 1'b0}]};

    // Read back configuration registers
    always_comb
    begin
        case (cfg_idx)
            cc20_pkg::REG_KEY_LOW:      prdata = key0_reg;
            cc20_pkg::REG_KEY_MID_LOW:  prdata = key1_reg;
            cc20_pkg::REG_KEY_MID_HIGH: prdata = key2_reg;
            cc20_pkg::REG_KEY_HIGH:     prdata = key3_reg;
            cc20_pkg::REG_START_CNT:    prdata = start_reg;
            cc20_pkg::REG_NONCE:        prdata = nonce_reg;
            default:                    prdata = '0;
        endcase
    end

    // Sequencer, working state, counter, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            pos_reg     <= '0;
            work_reg    <= '0;
            data_reg    <= '0;
            blk_cnt_reg <= '0;
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            start_reg   <= '0;
            nonce_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            // Drop the output once taken, unless a new word replaces it
            if (m_valid_reg && m_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end

            // Write a configuration register; unknown indexes are dropped
            if (cfg_wr)
            begin
                case (cfg_idx)
                    cc20_pkg::REG_KEY_LOW:      key0_reg <= pwdata;
                    cc20_pkg::REG_KEY_MID_LOW:  key1_reg <= pwdata;
                    cc20_pkg::REG_KEY_MID_HIGH: key2_reg <= pwdata;
                    cc20_pkg::REG_KEY_HIGH:     key3_reg <= pwdata;
                    cc20_pkg::REG_START_CNT:
                    begin
                        start_reg   <= pwdata;
                        blk_cnt_reg <= pwdata;
                    end
                    cc20_pkg::REG_NONCE:        nonce_reg <= pwdata;
                    default:                    ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (pos_reg == 3'd0)
                        begin
                            // Start a new block: hold the word, load the input state
                            data_reg  <= s_tdata;
                            work_reg  <= init_state;
                            step_reg  <= '0;
                            state_reg <= ST_ROUND;
                        end
                        else
                        begin
                            m_data_reg  <= s_tdata ^ ks_word;
                            m_last_reg  <= (pos_reg == LAST_POS);
                            m_valid_reg <= 1'b1;
                            pos_reg     <= 3'(pos_reg + 3'd1);
                        end
                    end
                end
                ST_ROUND:
                begin
                    work_reg <= round_out;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_FEED;
                    end
                    else
                    begin
                        step_reg <= CNT_W'(step_reg + 1'b1);
                    end
                end
                ST_FEED:
                begin
                    // Add the input state back and advance the block counter
                    for (int i = 0; i < 16; i++)
                    begin
                        work_reg[i] <= work_reg[i] + init_state[i];
                    end
                    blk_cnt_reg <= blk_cnt_reg + 64'd1;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= data_reg ^ {work_reg[1], work_reg[0]};
                        m_last_reg  <= (LAST_POS == 3'd0);
                        m_valid_reg <= 1'b1;
                        pos_reg     <= 3'(LAST_POS == 3'd0 ? 3'd0 : 3'd1);
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/cc20_round.sv]
`default_nettype none
module cc20_round (
    input  wire cc20_pkg::state_t     state_in,
    input  wire cc20_pkg::round_ctl_t ctl,
    output cc20_pkg::state_t          state_out
);

    // Apply one half quarter round to all four columns or all four diagonals
    always_comb
    begin
        int sh;
        int ib;
        int ic;
        int id;
        cc20_pkg::quad_t q_in;
        cc20_pkg::quad_t q_out;
        state_out = state_in;
        sh = ctl.diag ? 1 : 0;
        for (int i = 0; i < 4; i++)
        begin
            ib = 4 + ((i + sh) & 3);
            ic = 8 + ((i + 2 * sh) & 3);
            id = 12 + ((i + 3 * sh) & 3);
            q_in.a = state_in[i];
            q_in.b = state_in[ib];
            q_in.c = state_in[ic];
            q_in.d = state_in[id];
            q_out = cc20_pkg::half_qr(q_in, ctl.second);
            state_out[i]  = q_out.a;
            state_out[ib] = q_out.b;
            state_out[ic] = q_out.c;
            state_out[id] = q_out.d;
        end
    end

endmodule
`default_nettype wire

[tb/tb_chacha20_stream_cipher.sv]
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 1340;

    // Indexes past the last register; writes there must change nothing
    localparam logic [2:0] REG_SPARE_0 = 3'd6;
    localparam logic [2:0] REG_SPARE_1 = 3'd7;

    typedef struct packed {
        logic [cc20_pkg::DATA_W-1:0] data;
        logic                        last;
    } cipher_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [cc20_pkg::DATA_W-1:0]  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b1;
    logic [cc20_pkg::DATA_W-1:0]  m_tdata;
    logic                         m_tlast;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [cc20_pkg::ADDR_W-1:0]  paddr = '0;
    logic [cc20_pkg::CFG_W-1:0]   pwdata = '0;
    logic [cc20_pkg::CFG_W-1:0]   prdata;
    logic                         pready;

    // Keystream predictor state
    logic [63:0]        key_words [4];
    logic [63:0]        nonce_reg;
    logic [63:0]        block_ctr;
    logic [63:0]        keystream_words [8];
    logic [2:0]         word_pos;

    cipher_word_t       cipher_expect_q [$];
    bit                 idle_on = 1'b1;
    int                 hold_len = 0;
    int                 mismatch_count = 0;
    int                 words_sent = 0;
    int                 words_checked = 0;
    int                 blocks_made = 0;
    int                 counter_wraps = 0;
    int                 cfg_writes = 0;
    int                 idle_cycles = 0;

    chacha20_stream_cipher uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cc20_pkg::word_t rotl(cc20_pkg::word_t v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic cc20_pkg::state_t quad_mix(cc20_pkg::state_t w,
                                                   int a, int b, int c, int d);
        w[a] = w[a] + w[b];
        w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d];
        w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b];
        w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d];
        w[b] = rotl(w[b] ^ w[c], 7);
        return w;
    endfunction

    // Run the block function on the current key, counter and nonce
    function automatic void refill_keystream();
        cc20_pkg::state_t init;
        cc20_pkg::state_t w;
        init[0] = cc20_pkg::SIGMA0;
        init[1] = cc20_pkg::SIGMA1;
        init[2] = cc20_pkg::SIGMA2;
        init[3] = cc20_pkg::SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_words[i][31:0];
            init[5 + 2 * i] = key_words[i][63:32];
        end
        init[12] = block_ctr[31:0];
        init[13] = block_ctr[63:32];
        init[14] = nonce_reg[31:0];
        init[15] = nonce_reg[63:32];
        w = init;
        for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS_DEF; r++)
        begin
            w = quad_mix(w, 0, 4, 8, 12);
            w = quad_mix(w, 1, 5, 9, 13);
            w = quad_mix(w, 2, 6, 10, 14);
            w = quad_mix(w, 3, 7, 11, 15);
            w = quad_mix(w, 0, 5, 10, 15);
            w = quad_mix(w, 1, 6, 11, 12);
            w = quad_mix(w, 2, 7, 8, 13);
            w = quad_mix(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 8; i++)
            keystream_words[i] = {w[2 * i + 1] + init[2 * i + 1], w[2 * i] + init[2 * i]};
        if (block_ctr == '1)
            counter_wraps++;
        block_ctr = block_ctr + 64'd1;
        blocks_made++;
    endfunction

    function automatic cipher_word_t predict_cipher_word(logic [63:0] din);
        cipher_word_t r;
        if (word_pos == 3'd0)
            refill_keystream();
        r.data = din ^ keystream_words[word_pos];
        r.last = (word_pos == 3'(cc20_pkg::BLOCK_WORDS - 1));
        word_pos = word_pos + 3'd1;
        return r;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("MISMATCH %s on word %0d: expected %h, got %h",
                     what, words_checked, exp_v, got_v);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        case (idx)
            cc20_pkg::REG_KEY_LOW:      key_words[0] = value;
            cc20_pkg::REG_KEY_MID_LOW:  key_words[1] = value;
            cc20_pkg::REG_KEY_MID_HIGH: key_words[2] = value;
            cc20_pkg::REG_KEY_HIGH:     key_words[3] = value;
            cc20_pkg::REG_START_CNT:    block_ctr = value;
            cc20_pkg::REG_NONCE:        nonce_reg = value;
            default:                    ;
        endcase
    endtask

    // Offer one word, with an occasional gap in front of it
    task automatic send_word(input logic [63:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        cipher_expect_q.push_back(predict_cipher_word(w));
        words_sent++;
    endtask

    // Stop offering and wait until every outstanding word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cipher_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_word(64'h0000_0000_0000_0000);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'h5555_5555_5555_5555);
        send_word(64'hAAAA_AAAA_AAAA_AAAA);
        send_word(64'h0000_0000_0000_0001);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'h0123_4567_89AB_CDEF);
        send_word(64'hFEDC_BA98_7654_3210);
        drain();
    endtask

    // Counter at all ones: the second block runs with counter zero
    task automatic test_counter_wrap();
        cfg_write(cc20_pkg::REG_KEY_LOW, '1);
        cfg_write(cc20_pkg::REG_KEY_MID_LOW, '1);
        cfg_write(cc20_pkg::REG_KEY_MID_HIGH, '1);
        cfg_write(cc20_pkg::REG_KEY_HIGH, '1);
        cfg_write(cc20_pkg::REG_NONCE, '1);
        cfg_write(cc20_pkg::REG_START_CNT, '1);
        for (int i = 0; i < 10; i++)
            send_word({$urandom, $urandom});
        drain();
    endtask

    // New settings written two words into a block; the block keeps its keystream
    task automatic test_write_mid_block();
        cfg_write(cc20_pkg::REG_KEY_LOW, 64'h0706_0504_0302_0100);
        cfg_write(cc20_pkg::REG_KEY_MID_HIGH, 64'h1716_1514_1312_1110);
        cfg_write(cc20_pkg::REG_START_CNT, 64'd5);
        cfg_write(cc20_pkg::REG_NONCE, 64'h4A00_0000_0900_0000);
        for (int i = 0; i < 7; i++)
            send_word({$urandom, $urandom});
        drain();
    endtask

    task automatic test_unused_address();
        cfg_write(REG_SPARE_0, '1);
        cfg_write(REG_SPARE_1, {$urandom, $urandom});
    endtask

    // Phases of random length with fresh settings in between, often mid-block
    task automatic test_random_traffic();
        int len;
        while (words_sent < RANDOM_WORDS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_LOW, pick_value());
            if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_MID_LOW, pick_value());
            if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_MID_HIGH, pick_value());
            if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_KEY_HIGH, pick_value());
            if ($urandom_range(0, 1)) cfg_write(cc20_pkg::REG_NONCE, pick_value());
            if ($urandom_range(0, 7) == 0) cfg_write(REG_SPARE_0, pick_value());
            case ($urandom_range(0, 5))
                0: cfg_write(cc20_pkg::REG_START_CNT,
                             64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2));
                1: cfg_write(cc20_pkg::REG_START_CNT,
                             64'h0000_0000_FFFF_FFFF - $urandom_range(0, 2));
                2: cfg_write(cc20_pkg::REG_START_CNT, pick_value());
                default: ;
            endcase
            len = $urandom_range(1, 120);
            for (int i = 0; i < len; i++)
                send_word(pick_value());
            drain();
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_word({$urandom, $urandom});
        drain();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        cfg_write(cc20_pkg::REG_START_CNT, {$urandom, $urandom});
        for (int i = 0; i < 120; i++)
            send_word({$urandom, $urandom});
        drain();
    endtask

    // Receiver ready: long hold-off on request, else random stall bursts
    always
    begin
        @(posedge clk);
        if (hold_len > 0)
        begin
            m_tready <= 1'b0;
            repeat (hold_len) @(posedge clk);
            hold_len = 0;
            m_tready <= 1'b1;
        end
        else if (idle_on && rst_n && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            m_tready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected word
    always @(posedge clk)
    begin
        cipher_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_expect_q.size() == 0)
            begin
                report_mismatch("unexpected word", '0, m_tdata);
            end
            else
            begin
                exp_w = cipher_expect_q.pop_front();
                if (m_tdata !== exp_w.data)
                    report_mismatch("data_out", exp_w.data, m_tdata);
                if (m_tlast !== exp_w.last)
                    report_mismatch("block_end", 64'(exp_w.last), 64'(m_tlast));
            end
            words_checked++;
        end
    end

    // Watchdog on cycles with no transaction on any port
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
            key_words[i] = '0;
        nonce_reg = '0;
        block_ctr = '0;
        word_pos  = '0;
        for (int i = 0; i < 8; i++)
            keystream_words[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_counter_wrap();
        test_write_mid_block();
        test_unused_address();
        test_random_traffic();
        test_backpressure();
        test_full_rate();

        repeat (60) @(posedge clk);
        if (cipher_expect_q.size() != 0)
            report_mismatch("words never returned", '0, 64'(cipher_expect_q.size()));
        $display("Checked %0d of %0d words over %0d keystream blocks, %0d counter wraps",
                 words_checked, words_sent, blocks_made, counter_wraps);
        $display("Register writes: %0d, with random stalls, a long hold-off and full rate",
                 cfg_writes);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/cc20_pkg.sv
rtl/core/cc20_round.sv
rtl/core/chacha20_stream_cipher.sv
tb/tb_chacha20_stream_cipher.sv
